// ----- rtl/utf8_stream_validator_macros.svh -----
// Assertion macros for the UTF-8 stream validator.
// Expects clk and arst_n in the scope of each use.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

// same-cycle implication
`define UTF8V_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UTF8V_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/utf8v_pkg.sv -----
// Shared types and constants of the UTF-8 stream validator.
// No dependencies.
`default_nettype none

package utf8v_pkg;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_INVALID = 2'd1,
		ST_TRUNC   = 2'd2
	} status_t;

	localparam logic [20:0] CP_MIN2   = 21'h000080;
	localparam logic [20:0] CP_MIN3   = 21'h000800;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;
	localparam logic [20:0] CP_MIN4   = 21'h010000;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;

	// results caused by one input byte
	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] bytes;
		logic [20:0]     cp;
		status_t         status;
	} run_t;

	// sequence state seen by the top level
	typedef struct packed {
		logic [2:0] exp_len;
		logic [1:0] cnt;
		logic       err;
	} seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/utf8_stream_validator.sv -----
// Top level of the UTF-8 stream validator: input register, decode core, serializer.
// Depends on utf8v_pkg, utf8v_core, utf8v_emit and the assertion macro header.
//
//   channel | dir | tdata                         | tuser  | tlast
//   s_*     | in  | data_byte[7:0]                | -      | end_of_stream
//   m_*     | out | out_byte[7:0], code_point[28:8] | status | last_of_run
//
// Each accepted byte waits in the input register while the core decodes it; its run of
// 0 to 4 result beats then leaves the serializer one beat per cycle while m_tready is high.
// Bytes that cause no result pass through without waiting for the output.
// Reset clears the sequence state and both valid flags; no clearing pass.
// A stalled output holds its beat; the input register keeps taking a byte while
// the serializer finishes its last beat.
`default_nettype none
`include "utf8_stream_validator_macros.svh"

module utf8_stream_validator import utf8v_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
	input  wire logic        s_tlast,   // end_of_stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // out_byte[7:0], code_point[28:8], zero[31:29]
	output logic [1:0]       m_tuser,   // status[1:0]
	output logic             m_tlast    // last_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       emit_ready;
	logic       advance;
	logic       load;
	run_t       run;
	seq_state_t seq;

	assign advance  = valid_s1 && (emit_ready || run.n == 3'd0);
	assign load     = advance && run.n != 3'd0;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	utf8v_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_byte (byte_s1),
		.in_eos  (eos_s1),
		.run     (run),
		.seq     (seq)
	);

	utf8v_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.run_in   (run),
		.ready    (emit_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`UTF8V_ASSERT_NOW(a_held_bound, seq.exp_len != 3'd0, seq.cnt != 2'd0 && {1'b0, seq.cnt} < seq.exp_len, "held count out of range for open sequence")
	`UTF8V_ASSERT_NOW(a_err_single, load && run.status != ST_VALID, run.n == 3'd1, "error run longer than one beat")
	`UTF8V_ASSERT_NOW(a_no_run_after_err, valid_s1 && seq.err, run.n == 3'd0, "result produced after error")
	`UTF8V_ASSERT_NEXT(a_load_shows, load, m_tvalid && m_tdata[28:8] == $past(run.cp), "loaded run not presented")

endmodule

`default_nettype wire

// ----- rtl/utf8v_core.sv -----
// Sequence state and decode logic: turns one registered byte into a run of results.
// Depends on utf8v_pkg.
`default_nettype none

module utf8v_core import utf8v_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_eos,
	output run_t            run,
	output seq_state_t      seq
);

	logic [2:0]  exp_len_q, exp_len_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [20:0] pv_q, pv_d;
	logic        err_q, err_d;
	logic [7:0]  held_q [3];
	logic        hold_we;
	logic [1:0]  hold_idx;
	logic [20:0] cp_ext;
	logic [2:0]  len;
	logic        complete;
	logic        ok;

	assign cp_ext = {pv_q[14:0], in_byte[5:0]};
	assign len    = {1'b0, cnt_q} + 3'd1;

	always_comb begin
		run.n      = 3'd0;
		run.bytes  = {in_byte, held_q[2], held_q[1], held_q[0]};
		run.cp     = '0;
		run.status = ST_VALID;
		exp_len_d  = exp_len_q;
		cnt_d      = cnt_q;
		pv_d       = pv_q;
		err_d      = err_q;
		hold_we    = 1'b0;
		hold_idx   = cnt_q;
		complete   = (len >= exp_len_q) || (cnt_q == 2'd3);
		ok         = in_byte[7:6] == 2'b10;
		if (cnt_q >= 2'd2 && held_q[1][7:6] != 2'b10) ok = 1'b0;
		if (cnt_q == 2'd3 && held_q[2][7:6] != 2'b10) ok = 1'b0;
		if (len == 3'd2 && cp_ext < CP_MIN2) ok = 1'b0;
		if (len == 3'd3 && (cp_ext < CP_MIN3 || (cp_ext >= SURR_LO && cp_ext <= SURR_HI)))
			ok = 1'b0;
		if (len == 3'd4 && (cp_ext < CP_MIN4 || cp_ext > CP_MAX)) ok = 1'b0;

		if (err_q) begin
			run.n = 3'd0;
		end else if (exp_len_q == 3'd0) begin
			if (in_byte[7] == 1'b0) begin
				run.n        = 3'd1;
				run.bytes[0] = in_byte;
				run.cp       = {13'd0, in_byte};
			end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
				in_byte[7:3] == 5'b11110) begin
				if (in_eos) begin
					run.n      = 3'd1;
					run.bytes  = '0;
					run.status = ST_TRUNC;
				end else begin
					hold_we  = 1'b1;
					hold_idx = 2'd0;
					cnt_d    = 2'd1;
					if (in_byte[7:5] == 3'b110) begin
						exp_len_d = 3'd2;
						pv_d      = {16'd0, in_byte[4:0]};
					end else if (in_byte[7:4] == 4'b1110) begin
						exp_len_d = 3'd3;
						pv_d      = {17'd0, in_byte[3:0]};
					end else begin
						exp_len_d = 3'd4;
						pv_d      = {18'd0, in_byte[2:0]};
					end
				end
			end else begin
				run.n      = 3'd1;
				run.bytes  = '0;
				run.status = ST_INVALID;
				err_d      = 1'b1;
			end
		end else if (complete) begin
			if (ok) begin
				run.n            = len;
				run.bytes[cnt_q] = in_byte;
				run.cp           = cp_ext;
			end else begin
				run.n      = 3'd1;
				run.bytes  = '0;
				run.status = ST_INVALID;
				err_d      = 1'b1;
			end
			exp_len_d = 3'd0;
			cnt_d     = 2'd0;
			pv_d      = '0;
		end else begin
			hold_we = 1'b1;
			cnt_d   = cnt_q + 2'd1;
			pv_d    = cp_ext;
			if (in_eos) begin
				run.n      = 3'd1;
				run.bytes  = '0;
				run.status = ST_TRUNC;
			end
		end

		if (in_eos) begin
			exp_len_d = 3'd0;
			cnt_d     = 2'd0;
			pv_d      = '0;
			err_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= 3'd0;
			cnt_q     <= 2'd0;
			pv_q      <= '0;
			err_q     <= 1'b0;
		end else if (advance) begin
			exp_len_q <= exp_len_d;
			cnt_q     <= cnt_d;
			pv_q      <= pv_d;
			err_q     <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hold_we) begin
			held_q[hold_idx] <= in_byte;
		end
	end

	assign seq.exp_len = exp_len_q;
	assign seq.cnt     = cnt_q;
	assign seq.err     = err_q;

endmodule

`default_nettype wire

// ----- rtl/utf8v_emit.sv -----
// Result register and serializer: holds one run and sends it one beat per cycle while m_tready is high.
// Depends on utf8v_pkg.
`default_nettype none

module utf8v_emit import utf8v_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire run_t        run_in,
	output logic             ready,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // out_byte[7:0], code_point[28:8], zero[31:29]
	output logic [1:0]       m_tuser,  // status[1:0]
	output logic             m_tlast   // last_of_run
);

	run_t       run_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic       done;

	assign m_tvalid = valid_s2;
	assign m_tlast  = {1'b0, idx_q} == (run_s2.n - 3'd1);
	assign m_tdata  = {3'd0, run_s2.cp, run_s2.bytes[idx_q]};
	assign m_tuser  = run_s2.status;
	assign done     = valid_s2 && m_tready && m_tlast;
	assign ready    = !valid_s2 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && m_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_s2 <= run_in;
		end
	end

endmodule

`default_nettype wire

// ----- tb/utf8_stream_validator_tb.sv -----
// Self-checking testbench for utf8_stream_validator: a directed table, then random
// UTF-8 streams (well-formed text, broken sequences, noise), all with random idling.
// Depends on utf8v_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 100ps

module utf8_stream_validator_tb;
	import utf8v_pkg::*;

	localparam int PRED       = -1;
	localparam int RANDOM_LEN = 360;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN      = 20;
	localparam int N_DIR      = 26;

	typedef struct packed {
		logic [7:0]  octet;
		logic [20:0] cp;
		status_t     st;
		logic        last;
	} result_t;

	typedef struct {
		logic [7:0]  b;
		logic        eos;
		int          n;
		logic [7:0]  o;
		logic [20:0] cp;
		status_t     st;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	utf8_stream_validator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	// decoder state
	logic [7:0]  seq_bytes [3];
	logic [2:0]  seq_len;
	logic [1:0]  seq_cnt;
	logic [20:0] seq_val;
	logic        stream_bad;

	result_t     run_res [4];
	int          run_n;
	result_t     due_beats [$];
	int          fail_cnt = 0;
	int          live_cnt = 0;
	int          idle_cycles = 0;
	bit          snd_quiet = 0;
	bit          rcv_quiet = 0;

	row_t dir_rows [N_DIR] = '{
		'{8'h00, 1'b0, 1,    8'h00, 21'h00, ST_VALID},
		'{8'h7F, 1'b0, 1,    8'h7F, 21'h7F, ST_VALID},
		'{8'h80, 1'b0, 1,    8'h00, 21'h00, ST_INVALID},
		'{8'h41, 1'b0, 0,    8'h00, 21'h00, ST_VALID},
		'{8'h42, 1'b1, 0,    8'h00, 21'h00, ST_VALID},
		'{8'hC3, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'hA9, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'hE2, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'h82, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'hAC, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'hF4, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'h8F, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'hBF, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'hBF, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'hF4, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'h90, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'h80, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'h80, 1'b1, 1,    8'h00, 21'h00, ST_INVALID},
		'{8'hC0, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'h80, 1'b1, 1,    8'h00, 21'h00, ST_INVALID},
		'{8'hED, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'hA0, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'h80, 1'b1, 1,    8'h00, 21'h00, ST_INVALID},
		'{8'hE2, 1'b0, PRED, 8'h00, 21'h00, ST_VALID},
		'{8'h82, 1'b1, 1,    8'h00, 21'h00, ST_TRUNC},
		'{8'hFF, 1'b1, 1,    8'h00, 21'h00, ST_INVALID}
	};

	function automatic void clear_stream();
		seq_bytes  = '{8'h00, 8'h00, 8'h00};
		seq_len    = 3'd0;
		seq_cnt    = 2'd0;
		seq_val    = 21'd0;
		stream_bad = 1'b0;
	endfunction

	function automatic void add_result(logic [7:0] o, logic [20:0] cp, status_t st, logic last);
		run_res[run_n] = '{o, cp, st, last};
		run_n++;
	endfunction

	// results of one accepted byte go to run_res / run_n
	function automatic void decode_byte(input logic [7:0] b, input logic eos);
		int          len;
		int          cnt;
		logic [20:0] cp;
		logic        ok;
		run_n = 0;
		if (stream_bad) begin
			run_n = 0;
		end else if (seq_len == 3'd0) begin
			len = 0;
			cp = 21'd0;
			if (b[7] == 1'b0) begin
				len = 1; cp = {14'd0, b[6:0]};
			end else if (b[7:5] == 3'b110) begin
				len = 2; cp = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				len = 3; cp = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				len = 4; cp = {18'd0, b[2:0]};
			end
			if (len == 0) begin
				add_result(8'h00, 21'd0, ST_INVALID, 1'b1);
				stream_bad = 1'b1;
			end else if (len == 1) begin
				add_result(b, cp, ST_VALID, 1'b1);
			end else if (eos) begin
				add_result(8'h00, 21'd0, ST_TRUNC, 1'b1);
			end else begin
				seq_bytes[0] = b;
				seq_cnt = 2'd1;
				seq_len = len[2:0];
				seq_val = cp;
			end
		end else begin
			cnt = int'(seq_cnt);
			cp = {seq_val[14:0], b[5:0]};
			if (cnt + 1 >= seq_len || cnt >= 3) begin
				ok = (b[7:6] == 2'b10);
				for (int i = 1; i < cnt; i++)
					if (seq_bytes[i][7:6] != 2'b10) ok = 1'b0;
				case (cnt + 1)
					2: if (cp < CP_MIN2) ok = 1'b0;
					3: if (cp < CP_MIN3 || (cp >= SURR_LO && cp <= SURR_HI)) ok = 1'b0;
					4: if (cp < CP_MIN4 || cp > CP_MAX) ok = 1'b0;
					default: ;
				endcase
				if (ok) begin
					for (int i = 0; i < cnt; i++)
						add_result(seq_bytes[i], cp, ST_VALID, 1'b0);
					add_result(b, cp, ST_VALID, 1'b1);
				end else begin
					add_result(8'h00, 21'd0, ST_INVALID, 1'b1);
					stream_bad = 1'b1;
				end
				seq_len = 3'd0;
				seq_cnt = 2'd0;
				seq_val = 21'd0;
			end else begin
				seq_bytes[cnt] = b;
				seq_cnt = 2'(cnt + 1);
				seq_val = cp;
				if (eos)
					add_result(8'h00, 21'd0, ST_TRUNC, 1'b1);
			end
		end
		if (eos)
			clear_stream();
	endfunction

	// typed_n of PRED takes the decoder's results; otherwise typed_n results of typed_r
	task automatic send_beat(input logic [7:0] b, input logic eos, input int typed_n,
			input result_t typed_r);
		int gap;
		if ($urandom_range(0, 29) == 0)
			snd_quiet = !snd_quiet;
		gap = snd_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eos;
		do @(posedge clk); while (!s_tready);
		live_cnt++;
		decode_byte(b, eos);
		if (typed_n == PRED) begin
			for (int i = 0; i < run_n; i++)
				due_beats.push_back(run_res[i]);
		end else begin
			for (int i = 0; i < typed_n; i++)
				due_beats.push_back(typed_r);
		end
	endtask

	// output side: random stall before each beat
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rcv_quiet = !rcv_quiet;
			stall = rcv_quiet ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_beats.size() == 0) begin
				$display("%0t: unexpected beat: expected none, got byte %h cp %h status %0d last %b",
					$time, m_tdata[7:0], m_tdata[28:8], m_tuser, m_tlast);
				fail_cnt++;
			end else begin
				want = due_beats.pop_front();
				if (m_tdata[7:0] !== want.octet) begin
					$display("%0t: out_byte expected %h got %h", $time, want.octet, m_tdata[7:0]);
					fail_cnt++;
				end
				if (m_tdata[28:8] !== want.cp) begin
					$display("%0t: code_point expected %h got %h", $time, want.cp, m_tdata[28:8]);
					fail_cnt++;
				end
				if (m_tuser !== want.st) begin
					$display("%0t: status expected %0d got %0d", $time, want.st, m_tuser);
					fail_cnt++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last_of_run expected %b got %b", $time, want.last, m_tlast);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("FAIL utf8_stream_validator");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0]  tok [4];
		logic [20:0] cp;
		int          klen;
		int          tlen;
		int          kind;
		int          idx;
		int          raw;
		bit          corrupt;
		bit          eos_tok;
		clear_stream();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].n,
				'{dir_rows[i].o, dir_rows[i].cp, dir_rows[i].st, 1'b1});

		live_cnt = 0;
		while (live_cnt < RANDOM_LEN) begin
			// hold off until the output has caught up
			if (live_cnt % 120 == 0) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (due_beats.size() != 0);
			end
			kind = $urandom_range(0, 99);
			raw = -1;
			corrupt = 1'b0;
			tlen = 0;
			eos_tok = 1'b0;
			if (kind < 30) begin
				klen = 1; cp = 21'($urandom_range(0, 'h7F));
			end else if (kind < 50) begin
				klen = 2; cp = 21'($urandom_range('h80, 'h7FF));
			end else if (kind < 65) begin
				klen = 3;
				do cp = 21'($urandom_range('h800, 'hFFFF));
				while (cp >= SURR_LO && cp <= SURR_HI);
			end else if (kind < 78) begin
				klen = 4; cp = 21'($urandom_range('h10000, 'h10FFFF));
			end else begin
				case ($urandom_range(0, 6))
					0: begin
						klen = $urandom_range(2, 4);
						cp = 21'((klen == 2) ? $urandom_range(0, 'h7F) :
							(klen == 3) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF));
					end
					1: begin
						klen = 3; cp = 21'($urandom_range('hD800, 'hDFFF));
					end
					2: begin
						klen = 4; cp = 21'($urandom_range('h110000, 'h1FFFFF));
					end
					3: begin
						klen = $urandom_range(2, 4);
						cp = 21'((klen == 2) ? $urandom_range('h80, 'h7FF) :
							(klen == 3) ? $urandom_range('h800, 'hD7FF) :
							$urandom_range('h10000, 'h10FFFF));
						corrupt = 1'b1;
					end
					4: begin
						klen = 1; cp = 21'd0;
						raw = $urandom_range(0, 1) ? $urandom_range('h80, 'hBF) :
							$urandom_range('hF8, 'hFF);
					end
					5: begin
						klen = $urandom_range(2, 4);
						cp = 21'($urandom_range(0, 'h1FFFFF));
						tlen = $urandom_range(1, klen - 1);
						eos_tok = 1'b1;
					end
					default: begin
						klen = 1; cp = 21'd0; raw = $urandom_range(0, 255);
					end
				endcase
			end
			case (klen)
				1: tok[0] = {1'b0, cp[6:0]};
				2: begin
					tok[0] = {3'b110, cp[10:6]};
					tok[1] = {2'b10, cp[5:0]};
				end
				3: begin
					tok[0] = {4'b1110, cp[15:12]};
					tok[1] = {2'b10, cp[11:6]};
					tok[2] = {2'b10, cp[5:0]};
				end
				default: begin
					tok[0] = {5'b11110, cp[20:18]};
					tok[1] = {2'b10, cp[17:12]};
					tok[2] = {2'b10, cp[11:6]};
					tok[3] = {2'b10, cp[5:0]};
				end
			endcase
			if (raw >= 0)
				tok[0] = raw[7:0];
			if (corrupt) begin
				idx = $urandom_range(1, klen - 1);
				do tok[idx][7:6] = 2'($urandom_range(0, 3)); while (tok[idx][7:6] == 2'b10);
			end
			if (tlen == 0)
				tlen = klen;
			// end the stream now and then, sooner once it has gone bad
			if ($urandom_range(0, stream_bad ? 1 : 11) == 0)
				eos_tok = 1'b1;
			for (int i = 0; i < tlen; i++)
				send_beat(tok[i], eos_tok && (i == tlen - 1), PRED, '0);
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_beats.size() != 0);
		repeat (DRAIN) @(posedge clk);
		if (fail_cnt == 0 && due_beats.size() == 0)
			$display("PASS utf8_stream_validator");
		else
			$display("FAIL utf8_stream_validator");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/utf8v_pkg.sv
rtl/utf8v_core.sv
rtl/utf8v_emit.sv
rtl/utf8_stream_validator.sv
tb/utf8_stream_validator_tb.sv
